/* hdl/fprc_pkg.sv */
// shared types, constants and the crc-16 byte update for the framed packet receiver
// no dependencies; compiled first

package fprc_pkg;

    localparam int ByteWidth  = 8;
    localparam int WordWidth  = 16;
    localparam int CfgIdxWidth = 8;

    localparam logic [WordWidth-1:0] CrcPoly = 16'h1021;
    localparam logic [WordWidth-1:0] CrcInit = 16'hFFFF;
    localparam logic [WordWidth-1:0] CrcTop  = 16'h8000;

    localparam logic [ByteWidth-1:0] StartDelimReset = 8'd126;
    localparam logic [ByteWidth-1:0] EndDelimReset   = 8'd127;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_START_DELIM = 8'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_END_DELIM   = 8'd1;

    // parse phases
    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC_HI  = 3'd5;
    localparam logic [2:0] PH_CRC_LO  = 3'd6;
    localparam logic [2:0] PH_END     = 3'd7;

    // frame verdicts
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_GOOD    = 2'd1;
    localparam logic [1:0] ST_CRC_BAD = 2'd2;
    localparam logic [1:0] ST_END_BAD = 2'd3;

    typedef struct packed {
        logic [ByteWidth-1:0] start_delimiter;
        logic [ByteWidth-1:0] end_delimiter;
    } cfg_t;

    typedef struct packed {
        logic                 payload_valid;
        logic [ByteWidth-1:0] payload_byte;
        logic [WordWidth-1:0] payload_index;
        logic [ByteWidth-1:0] msg_type;
        logic [WordWidth-1:0] frame_length;
        logic [1:0]           frame_status;
    } result_t;

    typedef struct packed {
        logic [2:0] phase;
    } parse_status_t;

    // msb-first crc-16 update over one byte
    function automatic logic [WordWidth-1:0] crc_byte(
        input logic [WordWidth-1:0] c,
        input logic [ByteWidth-1:0] d
    );
        logic [WordWidth-1:0] v;
        v = c ^ {d, 8'h00};
        for (int k = 0; k < ByteWidth; k++)
        begin
            if ((v & CrcTop) != '0)
                v = {v[WordWidth-2:0], 1'b0} ^ CrcPoly;
            else
                v = {v[WordWidth-2:0], 1'b0};
        end
        return v;
    endfunction

endpackage

/* hdl/fprc_ifs.sv */
// valid/ready channel interfaces: received bytes, results and register writes
// depends on fprc_pkg

interface fprc_in_if;
    import fprc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface fprc_out_if;
    import fprc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 payload_valid;
    logic [ByteWidth-1:0] payload_byte;
    logic [WordWidth-1:0] payload_index;
    logic [ByteWidth-1:0] msg_type;
    logic [WordWidth-1:0] frame_length;
    logic [1:0]           frame_status;
    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output msg_type, output frame_length, output frame_status, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input msg_type, input frame_length, input frame_status, output ready
    );
endinterface

interface fprc_cfg_if;
    import fprc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CfgIdxWidth-1:0] index;
    logic [ByteWidth-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/fprc_parser.sv */
// frame parser: phase, held fields, payload count and running crc
// depends on fprc_pkg; produces the result for the byte being taken

module fprc_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [7:0]               rx_byte,
    input  fprc_pkg::cfg_t           cfg,
    output fprc_pkg::result_t        result,
    output fprc_pkg::parse_status_t  status
);
    import fprc_pkg::*;

    logic [2:0]           phase_reg, phase_next;
    logic [ByteWidth-1:0] type_reg, type_next;
    logic [WordWidth-1:0] length_reg, length_next;
    logic [WordWidth-1:0] count_reg, count_next;
    logic [WordWidth-1:0] rx_crc_reg, rx_crc_next;
    logic [WordWidth-1:0] run_crc_reg, run_crc_next;
    logic [WordWidth-1:0] crc_upd;
    logic [WordWidth-1:0] count_inc;
    logic [1:0]           verdict;

    assign crc_upd   = crc_byte(run_crc_reg, rx_byte);
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        rx_crc_next  = rx_crc_reg;
        run_crc_next = run_crc_reg;
        verdict      = ST_NONE;
        result       = '0;

        case (phase_reg)
            PH_START:
            begin
                if (rx_byte == cfg.start_delimiter)
                    phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                type_next    = rx_byte;
                run_crc_next = crc_upd;
                phase_next   = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next  = {rx_byte, 8'h00};
                run_crc_next = crc_upd;
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next  = {length_reg[15:8], rx_byte};
                run_crc_next = crc_upd;
                count_next   = '0;
                phase_next   = (length_next == '0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                run_crc_next         = crc_upd;
                count_next           = count_inc;
                if (count_inc >= length_reg)
                    phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                rx_crc_next = {rx_byte, 8'h00};
                phase_next  = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                rx_crc_next = {rx_crc_reg[15:8], rx_byte};
                phase_next  = PH_END;
            end
            PH_END:
            begin
                if (rx_byte != cfg.end_delimiter)
                    verdict = ST_END_BAD;
                else if (run_crc_reg == rx_crc_reg)
                    verdict = ST_GOOD;
                else
                    verdict = ST_CRC_BAD;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase

        result.msg_type     = type_next;
        result.frame_length = length_next;
        result.frame_status = verdict;

        // frame done: back to reset values
        if (verdict != ST_NONE)
        begin
            phase_next   = PH_START;
            type_next    = '0;
            length_next  = '0;
            count_next   = '0;
            rx_crc_next  = CrcInit;
            run_crc_next = CrcInit;
        end
    end

    assign status.phase = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            type_reg    <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            rx_crc_reg  <= CrcInit;
            run_crc_reg <= CrcInit;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            rx_crc_reg  <= rx_crc_next;
            run_crc_reg <= run_crc_next;
        end
    end

endmodule

/* hdl/fprc_out_stage.sv */
// result register between the parser and the result channel
// depends on fprc_pkg and fprc_out_if

module fprc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fprc_pkg::result_t data,
    output logic              can_load,
    fprc_out_if.source        res
);
    import fprc_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign res.valid         = valid_reg;
    assign res.payload_valid = data_reg.payload_valid;
    assign res.payload_byte  = data_reg.payload_byte;
    assign res.payload_index = data_reg.payload_index;
    assign res.msg_type      = data_reg.msg_type;
    assign res.frame_length  = data_reg.frame_length;
    assign res.frame_status  = data_reg.frame_status;

endmodule

/* hdl/framed_packet_receiver_crc16_core.sv */
// top level of the framed packet receiver with crc-16 check
// depends on fprc_pkg, fprc_ifs, fprc_parser and fprc_out_stage
//
// channel | dir | carries                                   | accepted when
// rx      | in  | rx_byte                                   | rx.valid && rx.ready
// res     | out | payload fields, msg_type, length, status  | res.valid && res.ready
// cfg     | in  | index, data (0 start, 1 end delimiter)    | cfg.valid && cfg.ready
//
// one item per cycle unless res stalls; each taken byte gives one result item next cycle
// phase decode and the crc compare sit between the parser state and the result register
// rx.ready drops only while the result register is full and res.ready is low
// cfg.ready is always high; rst_n resets phase, crc and counters and restores both delimiters

module framed_packet_receiver_crc16_core (
    input  logic        clk,
    input  logic        rst_n,
    fprc_in_if.sink     rx,
    fprc_out_if.source  res,
    fprc_cfg_if.sink    cfg
);
    import fprc_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    result_t       parse_result;
    parse_status_t parse_status;
    logic          can_load;
    logic          take;

    assign cfg.ready = 1'b1;
    assign rx.ready  = can_load;
    assign take      = rx.valid && can_load;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_DELIM: cfg_next.start_delimiter = cfg.data;
                CFG_END_DELIM:   cfg_next.end_delimiter   = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delimiter <= StartDelimReset;
            cfg_reg.end_delimiter   <= EndDelimReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fprc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg_reg),
        .result  (parse_result),
        .status  (parse_status)
    );

    fprc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .data     (parse_result),
        .can_load (can_load),
        .res      (res)
    );

    // end byte always closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        take && parse_status.phase == PH_END |=> parse_status.phase == PH_START)
        else $error("parser did not return to start after end byte");

    // a verdict never comes with a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_status != ST_NONE |-> !res.payload_valid)
        else $error("verdict and payload byte in one item");

    // payload index stays below the announced length
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload_valid |-> res.payload_index < res.frame_length)
        else $error("payload index beyond frame length");

    // input stalls only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> res.valid && !res.ready)
        else $error("input stalled without output back-pressure");

endmodule

/* sim/tb.sv */
// testbench for framed_packet_receiver_crc16_core: byte streams checked against a predictor
// depends on fprc_pkg, fprc_ifs and the rtl under hdl; one expected result item per byte sent

module tb;
    import fprc_pkg::*;

    typedef enum int {FRAME_GOOD, FRAME_CRC_ERR, FRAME_END_ERR, FRAME_CUT} frame_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    fprc_in_if  rx();
    fprc_out_if res();
    fprc_cfg_if cfg();

    framed_packet_receiver_crc16_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    // predicted parser state and delimiters
    logic [ByteWidth-1:0] sof_byte;
    logic [ByteWidth-1:0] eof_byte;
    logic [ByteWidth-1:0] cur_type;
    logic [2:0]           ph;
    logic [WordWidth-1:0] cur_len;
    logic [WordWidth-1:0] pay_cnt;
    logic [WordWidth-1:0] got_crc;
    logic [WordWidth-1:0] acc_crc;

    result_t exp_q[$];

    int errors       = 0;
    int n_sent       = 0;
    int framed_bytes = 0;
    int n_payload    = 0;
    int n_good       = 0;
    int n_crc_err    = 0;
    int n_end_err    = 0;
    int n_results    = 0;
    int n_settings   = 0;
    int send_idle    = 0;
    int recv_idle    = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    always #5 clk = ~clk;

    function automatic logic [WordWidth-1:0] crc16_step(
        input logic [WordWidth-1:0] c,
        input logic [ByteWidth-1:0] d
    );
        logic [WordWidth-1:0] r;
        logic                 fb;
        r = c;
        for (int i = ByteWidth - 1; i >= 0; i--)
        begin
            fb = r[WordWidth-1] ^ d[i];
            r  = {r[WordWidth-2:0], 1'b0};
            if (fb)
                r = r ^ CrcPoly;
        end
        return r;
    endfunction

    function automatic void clear_frame();
        ph       = PH_START;
        cur_type = '0;
        cur_len  = '0;
        pay_cnt  = '0;
        got_crc  = CrcInit;
        acc_crc  = CrcInit;
    endfunction

    function automatic result_t predict_byte(input logic [ByteWidth-1:0] b);
        result_t r;
        r = '0;
        case (ph)
            PH_START:
            begin
                if (b == sof_byte)
                begin
                    clear_frame();
                    ph = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                cur_type = b;
                acc_crc  = crc16_step(acc_crc, b);
                ph       = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                cur_len = {b, 8'h00};
                acc_crc = crc16_step(acc_crc, b);
                ph      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                cur_len[7:0] = b;
                acc_crc      = crc16_step(acc_crc, b);
                pay_cnt      = '0;
                ph           = (cur_len == '0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = pay_cnt;
                acc_crc         = crc16_step(acc_crc, b);
                pay_cnt         = pay_cnt + 16'd1;
                if (pay_cnt >= cur_len)
                    ph = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                got_crc = {b, 8'h00};
                ph      = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                got_crc[7:0] = b;
                ph           = PH_END;
            end
            default:
            begin
                if (b != eof_byte)
                    r.frame_status = ST_END_BAD;
                else if (acc_crc == got_crc)
                    r.frame_status = ST_GOOD;
                else
                    r.frame_status = ST_CRC_BAD;
            end
        endcase
        r.msg_type     = cur_type;
        r.frame_length = cur_len;
        if (r.frame_status != ST_NONE)
            clear_frame();
        return r;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic send_byte(input logic [ByteWidth-1:0] b);
        result_t r;
        while ($urandom_range(99) < send_idle)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        if (!(ph == PH_START && b != sof_byte))
            framed_bytes++;
        r = predict_byte(b);
        exp_q.push_back(r);
        n_sent++;
        if (r.payload_valid)
            n_payload++;
        case (r.frame_status)
            ST_GOOD:    n_good++;
            ST_CRC_BAD: n_crc_err++;
            ST_END_BAD: n_end_err++;
            default:    ;
        endcase
    endtask

    task automatic wait_idle();
        int guard;
        rx.valid <= 1'b0;
        guard = 0;
        while (exp_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [ByteWidth-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == CFG_START_DELIM)
            sof_byte = val;
        else if (idx == CFG_END_DELIM)
            eof_byte = val;
    endtask

    task automatic set_delims(input logic [ByteWidth-1:0] s, input logic [ByteWidth-1:0] e);
        wait_idle();
        write_reg(CFG_START_DELIM, s);
        write_reg(CFG_END_DELIM, e);
        cfg.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic send_frame(
        input logic [ByteWidth-1:0] mtype,
        input int unsigned          len,
        input frame_kind_t          kind,
        input bit                   fill_delim
    );
        logic [WordWidth-1:0] crc;
        logic [WordWidth-1:0] flen;
        logic [ByteWidth-1:0] b;
        int unsigned          cut;
        // finish whatever frame an earlier cut left open, start bytes included
        while (ph != PH_START)
            send_byte(($urandom_range(3) == 0) ? sof_byte : 8'($urandom_range(255)));
        flen = len[15:0];
        crc  = CrcInit;
        send_byte(sof_byte);
        send_byte(mtype);
        crc = crc16_step(crc, mtype);
        send_byte(flen[15:8]);
        crc = crc16_step(crc, flen[15:8]);
        send_byte(flen[7:0]);
        crc = crc16_step(crc, flen[7:0]);
        cut = (kind == FRAME_CUT) ? $urandom_range(len) : len;
        for (int unsigned i = 0; i < cut; i++)
        begin
            b = fill_delim ? sof_byte : 8'($urandom_range(255));
            send_byte(b);
            crc = crc16_step(crc, b);
        end
        if (kind == FRAME_CUT)
            return;
        if (kind == FRAME_CRC_ERR)
            crc = crc ^ 16'($urandom_range(1, 65535));
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        if (kind == FRAME_END_ERR)
            send_byte(eof_byte ^ 8'($urandom_range(1, 255)));
        else
            send_byte(eof_byte);
    endtask

    // reset delimiters, ignored bytes, empty frame, start byte as data, each verdict
    task automatic test_directed();
        send_idle = 0;
        recv_idle <= 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'hFF, 0, FRAME_GOOD, 1'b0);
        send_frame(sof_byte, 1, FRAME_CRC_ERR, 1'b1);
        send_frame(8'h00, 0, FRAME_END_ERR, 1'b0);
    endtask

    task automatic test_delimiter_extremes();
        logic [ByteWidth-1:0] s_list[4] = '{8'h00, 8'hFF, 8'h5A, 8'h81};
        logic [ByteWidth-1:0] e_list[4] = '{8'hFF, 8'h00, 8'h5A, 8'h18};
        send_idle = 21;
        recv_idle <= 21;
        for (int i = 0; i < 4; i++)
        begin
            set_delims(s_list[i], e_list[i]);
            send_byte(~sof_byte);
            send_frame(8'($urandom_range(255)), 2, FRAME_GOOD, 1'b0);
            send_frame(sof_byte, 0, FRAME_CRC_ERR, 1'b0);
            send_frame(eof_byte, 3, FRAME_END_ERR, 1'b1);
        end
    endtask

    task automatic test_random();
        int          send_pct[4] = '{0, 70, 0, 21};
        int          recv_pct[4] = '{0, 0, 70, 21};
        int          mark;
        int          sel;
        int unsigned len;
        logic [ByteWidth-1:0] b;
        logic [ByteWidth-1:0] mtype;
        frame_kind_t kind;
        for (int p = 0; p < 4; p++)
        begin
            if (p == 3)
                set_delims(StartDelimReset, EndDelimReset);
            else
                set_delims(8'($urandom_range(255)), 8'($urandom_range(255)));
            send_idle = send_pct[p];
            recv_idle <= recv_pct[p];
            mark = framed_bytes;
            while (framed_bytes - mark < 260)
            begin
                sel = $urandom_range(99);
                if (sel < 12)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        b = 8'($urandom_range(255));
                        if (b == sof_byte)
                            b = b ^ 8'h01;
                        send_byte(b);
                    end
                end
                else
                begin
                    sel = $urandom_range(99);
                    if (sel < 10)
                        len = 0;
                    else if (sel < 80)
                        len = $urandom_range(1, 8);
                    else if (sel < 99)
                        len = $urandom_range(9, 40);
                    else
                        len = $urandom_range(256, 271);
                    mtype = ($urandom_range(7) == 0) ? sof_byte : 8'($urandom_range(255));
                    sel = $urandom_range(99);
                    if (sel < 10)
                        kind = FRAME_CUT;
                    else if (sel < 65)
                        kind = FRAME_GOOD;
                    else if (sel < 82)
                        kind = FRAME_CRC_ERR;
                    else
                        kind = FRAME_END_ERR;
                    send_frame(mtype, len, kind, 1'b0);
                end
            end
        end
    endtask

    // receiver holds off while frames keep coming, then the sender waits for every result
    task automatic test_backpressure();
        send_idle = 0;
        recv_idle <= 0;
        hold_req <= hold_req + 1;
        repeat (8)
            send_frame(8'($urandom_range(255)), 8, FRAME_GOOD, 1'b0);
        wait_idle();
    endtask

    task automatic test_long_frame();
        send_idle = 0;
        recv_idle <= 0;
        send_frame(8'hA5, 260, FRAME_GOOD, 1'b0);
        wait_idle();
    endtask

    always @(posedge clk)
    begin : recv_side
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got.payload_valid = res.payload_valid;
            got.payload_byte  = res.payload_byte;
            got.payload_index = res.payload_index;
            got.msg_type      = res.msg_type;
            got.frame_length  = res.frame_length;
            got.frame_status  = res.frame_status;
            if (exp_q.size() == 0)
                note_error($sformatf(
                    "unexpected item: pv=%0d pb=%02h pi=%0d type=%02h len=%0d st=%0d",
                    got.payload_valid, got.payload_byte, got.payload_index,
                    got.msg_type, got.frame_length, got.frame_status));
            else
            begin
                want = exp_q.pop_front();
                if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte
                    || got.payload_index !== want.payload_index || got.msg_type !== want.msg_type
                    || got.frame_length !== want.frame_length
                    || got.frame_status !== want.frame_status)
                    note_error($sformatf(
                        {"item %0d: expected pv=%0d pb=%02h pi=%0d type=%02h len=%0d st=%0d, ",
                         "got pv=%0d pb=%02h pi=%0d type=%02h len=%0d st=%0d"},
                        n_results, want.payload_valid, want.payload_byte, want.payload_index,
                        want.msg_type, want.frame_length, want.frame_status,
                        got.payload_valid, got.payload_byte, got.payload_index,
                        got.msg_type, got.frame_length, got.frame_status));
            end
            n_results++;
        end
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        rx.valid   = 1'b0;
        rx.rx_byte = '0;
        cfg.valid  = 1'b0;
        cfg.index  = '0;
        cfg.data   = '0;
        sof_byte   = StartDelimReset;
        eof_byte   = EndDelimReset;
        clear_frame();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_delimiter_extremes();
        test_random();
        test_backpressure();
        test_long_frame();

        wait_idle();
        repeat (10) @(posedge clk);
        if (exp_q.size() != 0)
            note_error($sformatf("%0d expected items never arrived", exp_q.size()));

        $display("checked %0d result items from %0d bytes: %0d good, %0d crc error, %0d bad end",
            n_results, n_sent, n_good, n_crc_err, n_end_err);
        $display("%0d payload bytes, %0d delimiter settings, all idle mixes, hold-off, long frame",
            n_payload, n_settings);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
